// ===== rtl/core/pnlfr_pkg.sv =====
// pnlfr_pkg: shared types, constants and helpers of the pn lock and frame resync block
// holds the sync marker, its differential pattern, field widths and register indexes
// no dependencies
package pnlfr_pkg;

  // field widths
  localparam int SAMPLE_W   = 8;
  localparam int COUNT_W    = 63;
  localparam int MAG_W      = 7;
  localparam int SCORE_W    = 14;
  localparam int CFG_W      = 13;
  localparam int FBITS_W    = 20;
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int PAIR_W     = 2;
  localparam int POS_W      = 6;

  // 64-bit sync marker, sent msb first
  localparam logic [63:0] SYNC_MARKER = 64'h4BBB_B999_9555_7FFF;

  // frame bits that carry the timestamp
  localparam int STAMP_FIRST_BIT = 160;
  localparam int STAMP_END_BIT   = 224;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESYNC_ENABLE  = 2'd0,
    REG_LOCK_THRESHOLD = 2'd1,
    REG_SCORE_CEILING  = 2'd2,
    REG_FRAME_BITS     = 2'd3
  } cfg_reg_t;

  // pair counts of an output word
  localparam logic [PAIR_W-1:0] PAIR_ONE = 2'd1;
  localparam logic [PAIR_W-1:0] PAIR_TWO = 2'd2;

  // cumulative xor of the marker from its msb down to bit i
  function automatic logic [63:0] marker_run(input logic [63:0] m);
    logic [63:0] r;
    logic        acc;
    acc = 1'b0;
    r   = '0;
    for (int i = 63; i >= 0; i--) begin
      acc  = acc ^ m[i];
      r[i] = acc;
    end
    return r;
  endfunction

  // tx bit for marker bit i is the tx bit before the marker xor this
  localparam logic [63:0] MARKER_TX = marker_run(SYNC_MARKER);

  // soft symbol from a tx bit and a magnitude
  function automatic logic signed [SAMPLE_W-1:0] to_symbol(input logic t,
                                                           input logic [MAG_W-1:0] mag);
    logic [SAMPLE_W-1:0] m8;
    m8 = {1'b0, mag};
    return t ? signed'(m8) : signed'(SAMPLE_W'(0) - m8);
  endfunction

  // one output word handed from the step logic to the output stage
  typedef struct packed {
    logic                       lock;
    logic signed [SAMPLE_W-1:0] sym_a;
    logic signed [SAMPLE_W-1:0] sym_b;
    logic [PAIR_W-1:0]          pair_count;
    logic                       last;
    logic                       tx_base;
    logic [MAG_W-1:0]           mag;
  } step_word_t;

endpackage

// ===== rtl/core/pn_lock_frame_resync.sv =====
// pn_lock_frame_resync: top level of the pn resync and framing block
// depends on pnlfr_pkg and pnlfr_out
//
// usage: soft symbols enter on the sample channel (sample_valid, sample_stall,
// sample, sample_count); output words leave on the symbol channel
// (symbol_valid, symbol_stall, symbol_a, symbol_b, pair_count, last). each
// output word carries one or two soft symbols; last marks the final word of an
// input sample. a word moves at a clock edge with valid high and stall low.
// the block takes one sample per cycle while sample_stall is low; its first
// output word is registered as it is taken. every sample gives one word,
// except a lock on the sync marker, which gives 33 words, one per cycle while
// symbol_stall is low; sample_stall stays high while the first 32 of them are
// out and drops as the last one is loaded; it also follows symbol_stall while
// the output register holds a word. the output register decouples the sides,
// so a sample is taken in the cycle its predecessor's word is taken.
// configuration: wr_en, wr_index, wr_data write the registers; write only
// while the block is idle. reset (rst, synchronous, active high) returns the
// block to hunting with zero state and the default register values.
module pn_lock_frame_resync #(
  parameter int FRAME_INDEX_WIDTH = 20
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   sample_valid,
  output logic                                   sample_stall,
  input  logic signed [pnlfr_pkg::SAMPLE_W-1:0]  sample,
  input  logic [pnlfr_pkg::COUNT_W-1:0]          sample_count,
  output logic                                   symbol_valid,
  input  logic                                   symbol_stall,
  output logic signed [pnlfr_pkg::SAMPLE_W-1:0]  symbol_a,
  output logic signed [pnlfr_pkg::SAMPLE_W-1:0]  symbol_b,
  output logic [pnlfr_pkg::PAIR_W-1:0]           pair_count,
  output logic                                   last,
  input  logic                                   wr_en,
  input  logic [pnlfr_pkg::CFG_IDX_W-1:0]        wr_index,
  input  logic [pnlfr_pkg::CFG_DATA_W-1:0]       wr_data
);
  import pnlfr_pkg::*;

  localparam int FW = FRAME_INDEX_WIDTH;

  // configuration registers
  logic               resync_enable;
  logic [CFG_W-1:0]   lock_threshold;
  logic [CFG_W-1:0]   score_ceiling;
  logic [FBITS_W-1:0] frame_bits;

  // block state
  logic               prev_rx_bit;
  logic               prev_tx_bit;
  logic [63:0]        rx_history;
  logic [63:0]        pn_state;
  logic [SCORE_W-1:0] agree_score;
  logic               in_frame;
  logic [FW-1:0]      frame_bit_index;
  logic [63:0]        frame_stamp;

  // next values
  logic               prev_tx_bit_next;
  logic [63:0]        rx_history_next;
  logic [63:0]        pn_state_next;
  logic [SCORE_W-1:0] agree_score_next;
  logic               in_frame_next;
  logic [FW-1:0]      frame_bit_index_next;

  logic               accept;
  logic               busy;
  logic               now_bit;
  logic               rx_bit;
  logic               pn_bit;
  logic [MAG_W-1:0]   mag;
  logic [FW-1:0]      idx_inc;
  logic [FW-1:0]      stamp_off;
  logic [5:0]         stamp_sel;
  logic               in_stamp;
  logic               frame_bit;
  logic               tx_bit;
  logic               lock;
  step_word_t         word;

  assign sample_stall = busy || (symbol_valid && symbol_stall);
  assign accept       = sample_valid && !sample_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      resync_enable  <= 1'b1;
      lock_threshold <= CFG_W'(1000);
      score_ceiling  <= CFG_W'(5000);
      frame_bits     <= FBITS_W'(354848);
    end else if (wr_en) begin
      unique case (cfg_reg_t'(wr_index))
        REG_RESYNC_ENABLE:  resync_enable  <= wr_data[0];
        REG_LOCK_THRESHOLD: lock_threshold <= wr_data[CFG_W-1:0];
        REG_SCORE_CEILING:  score_ceiling  <= wr_data[CFG_W-1:0];
        REG_FRAME_BITS:     frame_bits     <= wr_data[FBITS_W-1:0];
        default:            ;
      endcase
    end
  end

  // slicing, differential decode and magnitude
  always_comb begin
    now_bit = !sample[SAMPLE_W-1] && (sample != '0);
    rx_bit  = prev_rx_bit ^ now_bit;
    if (sample == '0) begin
      mag = MAG_W'(1);
    end else if (sample == signed'({1'b1, {(SAMPLE_W-1){1'b0}}})) begin
      mag = {MAG_W{1'b1}};
    end else if (sample[SAMPLE_W-1]) begin
      mag = MAG_W'(SAMPLE_W'(0) - sample);
    end else begin
      mag = sample[MAG_W-1:0];
    end
    pn_bit = pn_state[13] ^ pn_state[14];
  end

  // timestamp position within the frame
  assign idx_inc   = frame_bit_index + FW'(1);
  assign stamp_off = frame_bit_index - FW'(STAMP_FIRST_BIT);
  assign stamp_sel = {stamp_off[5:3], ~stamp_off[2:0]};
  assign in_stamp  = (frame_bit_index >= FW'(STAMP_FIRST_BIT)) &&
                     (frame_bit_index < FW'(STAMP_END_BIT));
  assign frame_bit = in_stamp ? (frame_stamp[stamp_sel] ^ pn_bit ^ frame_bit_index[3])
                              : rx_bit;

  // per-sample state step and output word
  always_comb begin
    rx_history_next      = {rx_history[62:0], rx_bit};
    pn_state_next        = {pn_state[62:0], pn_bit};
    agree_score_next     = agree_score;
    in_frame_next        = in_frame;
    frame_bit_index_next = frame_bit_index;
    prev_tx_bit_next     = prev_tx_bit;
    lock                 = 1'b0;
    tx_bit               = prev_tx_bit;

    if (in_frame) begin
      // frame bit, with the timestamp bytes scrambled in
      tx_bit               = frame_bit ^ prev_tx_bit;
      prev_tx_bit_next     = tx_bit;
      frame_bit_index_next = idx_inc;
      if (idx_inc == FW'(frame_bits)) begin
        in_frame_next        = 1'b0;
        frame_bit_index_next = '0;
        agree_score_next     = '0;
      end
    end else begin
      // hunting: score update and generator reload
      if (rx_bit == pn_bit) begin
        if (agree_score < SCORE_W'(score_ceiling)) begin
          agree_score_next = agree_score + SCORE_W'(1);
        end
      end else if (agree_score <= SCORE_W'(2)) begin
        agree_score_next = SCORE_W'(1);
        pn_state_next    = rx_history_next;
      end else begin
        agree_score_next = agree_score - SCORE_W'(2);
      end
      // marker check
      if (pn_state_next == SYNC_MARKER &&
          agree_score_next > SCORE_W'(lock_threshold)) begin
        lock                 = 1'b1;
        in_frame_next        = 1'b1;
        frame_bit_index_next = '0;
        prev_tx_bit_next     = prev_tx_bit ^ MARKER_TX[0];
      end
    end

    word.lock    = 1'b0;
    word.tx_base = prev_tx_bit;
    word.mag     = mag;
    if (!resync_enable) begin
      word.sym_a      = sample;
      word.sym_b      = '0;
      word.pair_count = PAIR_ONE;
      word.last       = 1'b1;
    end else if (lock) begin
      word.lock       = 1'b1;
      word.sym_a      = to_symbol(tx_bit, mag);
      word.sym_b      = to_symbol(prev_tx_bit ^ MARKER_TX[63], mag);
      word.pair_count = PAIR_TWO;
      word.last       = 1'b0;
    end else begin
      word.sym_a      = to_symbol(tx_bit, mag);
      word.sym_b      = '0;
      word.pair_count = PAIR_ONE;
      word.last       = 1'b1;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_rx_bit     <= 1'b0;
      prev_tx_bit     <= 1'b0;
      rx_history      <= '0;
      pn_state        <= '0;
      agree_score     <= '0;
      in_frame        <= 1'b0;
      frame_bit_index <= '0;
      frame_stamp     <= '0;
    end else if (accept && resync_enable) begin
      prev_rx_bit     <= now_bit;
      prev_tx_bit     <= prev_tx_bit_next;
      rx_history      <= rx_history_next;
      pn_state        <= pn_state_next;
      agree_score     <= agree_score_next;
      in_frame        <= in_frame_next;
      frame_bit_index <= frame_bit_index_next;
      if (lock) begin
        frame_stamp <= {1'b0, sample_count};
      end
    end
  end

  // output register and marker burst
  pnlfr_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (accept),
    .word_in      (word),
    .symbol_stall (symbol_stall),
    .symbol_valid (symbol_valid),
    .symbol_a     (symbol_a),
    .symbol_b     (symbol_b),
    .pair_count   (pair_count),
    .last         (last),
    .busy         (busy)
  );

endmodule

// ===== rtl/core/pnlfr_out.sv =====
// pnlfr_out: output register of the resync block and the marker burst sequencer
// depends on pnlfr_pkg for the word struct, marker pattern and symbol helper
module pnlfr_out (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 load,
  input  pnlfr_pkg::step_word_t                word_in,
  input  logic                                 symbol_stall,
  output logic                                 symbol_valid,
  output logic signed [pnlfr_pkg::SAMPLE_W-1:0] symbol_a,
  output logic signed [pnlfr_pkg::SAMPLE_W-1:0] symbol_b,
  output logic [pnlfr_pkg::PAIR_W-1:0]         pair_count,
  output logic                                 last,
  output logic                                 busy
);
  import pnlfr_pkg::*;

  logic             burst_active;
  logic [POS_W-1:0] burst_pos;
  logic             burst_base;
  logic [MAG_W-1:0] burst_mag;
  logic             out_free;
  logic [POS_W-1:0] pos_b;
  logic             burst_end;

  assign out_free  = !symbol_valid || !symbol_stall;
  assign busy      = burst_active;
  assign pos_b     = burst_pos - POS_W'(1);
  assign burst_end = (burst_pos == '0);

  // control: valid and burst sequencing
  always_ff @(posedge clk) begin
    if (rst) begin
      symbol_valid <= 1'b0;
      burst_active <= 1'b0;
      burst_pos    <= '0;
    end else if (load) begin
      symbol_valid <= 1'b1;
      if (word_in.lock) begin
        burst_active <= 1'b1;
        burst_pos    <= POS_W'(62);
      end
    end else if (burst_active && out_free) begin
      symbol_valid <= 1'b1;
      if (burst_end) begin
        burst_active <= 1'b0;
      end else begin
        burst_pos <= burst_pos - POS_W'(2);
      end
    end else if (out_free) begin
      symbol_valid <= 1'b0;
    end
  end

  // payload: word from the step logic or the next marker pair
  always_ff @(posedge clk) begin
    if (load) begin
      symbol_a   <= word_in.sym_a;
      symbol_b   <= word_in.sym_b;
      pair_count <= word_in.pair_count;
      last       <= word_in.last;
      burst_base <= word_in.tx_base;
      burst_mag  <= word_in.mag;
    end else if (burst_active && out_free) begin
      symbol_a   <= to_symbol(burst_base ^ MARKER_TX[burst_pos], burst_mag);
      symbol_b   <= burst_end ? '0 : to_symbol(burst_base ^ MARKER_TX[pos_b], burst_mag);
      pair_count <= burst_end ? PAIR_ONE : PAIR_TWO;
      last       <= burst_end;
    end
  end

endmodule

// ===== tb/sv/pn_resync_sb_pkg.sv =====
`timescale 1ns / 100ps
// pn_resync_sb_pkg: scoreboard class for the pn lock and frame resync testbench
// predicts output words from accepted samples and checks them; depends on pnlfr_pkg
package pn_resync_sb_pkg;
  import pnlfr_pkg::*;

  // one predicted output word
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sym_a;
    logic signed [SAMPLE_W-1:0] sym_b;
    logic [PAIR_W-1:0]          pairs;
    logic                       fin;
  } out_word_t;

  class resync_scoreboard;
    // register copies
    logic               resync_on;
    logic [CFG_W-1:0]   lock_thr;
    logic [CFG_W-1:0]   ceiling;
    logic [FBITS_W-1:0] frame_len;
    // block state
    logic               rx_prev;
    logic               tx_prev;
    logic [63:0]        rx_hist;
    logic [63:0]        pn_reg;
    int                 score;
    logic               framing;
    logic [FBITS_W-1:0] bit_idx;
    logic [63:0]        stamp;
    // words still owed by the block
    out_word_t          expected_words[$];
    int                 errors;

    function new();
      resync_on = 1'b1;
      lock_thr  = CFG_W'(1000);
      ceiling   = CFG_W'(5000);
      frame_len = FBITS_W'(354848);
      rx_prev   = 1'b0;
      tx_prev   = 1'b0;
      rx_hist   = '0;
      pn_reg    = '0;
      score     = 0;
      framing   = 1'b0;
      bit_idx   = '0;
      stamp     = '0;
      errors    = 0;
    endfunction

    function void write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_RESYNC_ENABLE:  resync_on = v[0];
        REG_LOCK_THRESHOLD: lock_thr  = v[CFG_W-1:0];
        REG_SCORE_CEILING:  ceiling   = v[CFG_W-1:0];
        REG_FRAME_BITS:     frame_len = v[FBITS_W-1:0];
        default: ;
      endcase
    endfunction

    // differential re-encode of one bit into a soft symbol
    function logic [SAMPLE_W-1:0] encode_bit(logic b, logic [MAG_W-1:0] mag);
      tx_prev = b ^ tx_prev;
      return tx_prev ? {1'b0, mag} : SAMPLE_W'(SAMPLE_W'(0) - {1'b0, mag});
    endfunction

    // advance the state by one accepted sample and queue the words it causes
    function void note_sample(logic signed [SAMPLE_W-1:0] s, logic [COUNT_W-1:0] cnt);
      logic [SAMPLE_W-1:0] syms[$];
      logic                now_bit;
      logic                dec_bit;
      logic                pn_bit;
      logic                stamp_bit;
      logic [MAG_W-1:0]    mag;
      int                  abs_val;
      int                  off;
      int                  n;
      out_word_t           w;
      if (!resync_on) begin
        // pass through untouched
        syms.push_back(s);
      end else begin
        now_bit = (s > 0);
        dec_bit = rx_prev ^ now_bit;
        rx_prev = now_bit;
        abs_val = (s < 0) ? -int'(s) : int'(s);
        if (abs_val == 0) abs_val = 1;
        if (abs_val > 127) abs_val = 127;
        mag = MAG_W'(abs_val);
        pn_bit  = pn_reg[13] ^ pn_reg[14];
        rx_hist = {rx_hist[62:0], dec_bit};
        pn_reg  = {pn_reg[62:0], pn_bit};
        if (framing) begin
          // timestamp bytes are scrambled, everything else passes
          if (bit_idx >= STAMP_FIRST_BIT && bit_idx < STAMP_END_BIT) begin
            off = int'(bit_idx) - STAMP_FIRST_BIT;
            stamp_bit = stamp[8 * (off / 8) + 7 - (off % 8)];
            syms.push_back(encode_bit(stamp_bit ^ pn_bit ^ bit_idx[3], mag));
          end else begin
            syms.push_back(encode_bit(dec_bit, mag));
          end
          bit_idx = bit_idx + 1'b1;
          if (bit_idx == frame_len) begin
            framing = 1'b0;
            bit_idx = '0;
            score   = 0;
          end
        end else begin
          // agreement score with reload on collapse
          if (dec_bit == pn_bit) begin
            if (score < int'(ceiling)) score++;
          end else begin
            score -= 2;
            if (score <= 0) begin
              score  = 1;
              pn_reg = rx_hist;
            end
          end
          syms.push_back(encode_bit(1'b0, mag));
          // lock on the marker
          if (pn_reg == SYNC_MARKER && score > int'(lock_thr)) begin
            framing = 1'b1;
            bit_idx = '0;
            for (int k = 63; k >= 0; k--) syms.push_back(encode_bit(SYNC_MARKER[k], mag));
            stamp = {1'b0, cnt};
          end
        end
      end
      // pack two symbols per word
      n = syms.size();
      for (int k = 0; k < (n + 1) / 2; k++) begin
        w.sym_a = syms[2 * k];
        w.sym_b = (2 * k + 1 < n) ? syms[2 * k + 1] : '0;
        w.pairs = (2 * k + 1 < n) ? PAIR_TWO : PAIR_ONE;
        w.fin   = (k == (n + 1) / 2 - 1);
        expected_words.push_back(w);
      end
    endfunction

    task report(string msg);
      if (errors < 40) $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // compare one accepted word with the oldest prediction
    task check_word(logic signed [SAMPLE_W-1:0] a, logic signed [SAMPLE_W-1:0] b,
                    logic [PAIR_W-1:0] pc, logic lw);
      out_word_t w;
      if (expected_words.size() == 0) begin
        report($sformatf("word with nothing owed, symbol_a=%0d", a));
        return;
      end
      w = expected_words.pop_front();
      if (a !== w.sym_a) report($sformatf("symbol_a %0d, want %0d", a, w.sym_a));
      if (pc !== w.pairs) report($sformatf("pair_count %0d, want %0d", pc, w.pairs));
      if (w.pairs == PAIR_TWO && b !== w.sym_b)
        report($sformatf("symbol_b %0d, want %0d", b, w.sym_b));
      if (lw !== w.fin) report($sformatf("last %0b, want %0b", lw, w.fin));
    endtask
  endclass

endpackage

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// tb: top of the pn lock and frame resync testbench
// drives samples and registers, checks output words; depends on pnlfr_pkg and pn_resync_sb_pkg
module tb;
  import pnlfr_pkg::*;
  import pn_resync_sb_pkg::*;

  localparam int LOCK_RUN    = 72;
  localparam int CYCLE_LIMIT = 400000;

  logic                       clk;
  logic                       rst;
  logic                       sample_valid;
  logic                       sample_stall;
  logic signed [SAMPLE_W-1:0] sample;
  logic [COUNT_W-1:0]         sample_count;
  logic                       symbol_valid;
  logic                       symbol_stall;
  logic signed [SAMPLE_W-1:0] symbol_a;
  logic signed [SAMPLE_W-1:0] symbol_b;
  logic [PAIR_W-1:0]          pair_count;
  logic                       last;
  logic                       wr_en;
  logic [CFG_IDX_W-1:0]       wr_index;
  logic [CFG_DATA_W-1:0]      wr_data;

  int snd_idle = 33;
  int rcv_idle = 50;
  int cycles   = 0;

  // decoded bit run of the pn sequence that ends on the marker
  logic pn_run [LOCK_RUN];

  resync_scoreboard sb;

  pn_lock_frame_resync DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .sample_count (sample_count),
    .symbol_valid (symbol_valid),
    .symbol_stall (symbol_stall),
    .symbol_a     (symbol_a),
    .symbol_b     (symbol_b),
    .pair_count   (pair_count),
    .last         (last),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // output side: check taken words, random stall
  always @(posedge clk) begin
    if (!rst && symbol_valid && !symbol_stall)
      sb.check_word(symbol_a, symbol_b, pair_count, last);
    symbol_stall <= ($urandom_range(99) < rcv_idle);
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[pn_lock_frame_resync] ERROR");
      $finish;
    end
  end

  function automatic logic [COUNT_W-1:0] rand_count();
    return COUNT_W'({$urandom, $urandom});
  endfunction

  // present one word, hold it until taken, then let the scoreboard see it
  task automatic send_word(logic signed [SAMPLE_W-1:0] s, logic [COUNT_W-1:0] c);
    int gap;
    gap = 0;
    while ($urandom_range(99) < snd_idle && gap < 16) gap++;
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    sample_count <= c;
    do @(posedge clk); while (sample_stall);
    sb.note_sample(s, c);
  endtask

  task automatic send_noise(int n);
    repeat (n) send_word(SAMPLE_W'($urandom_range(255)), rand_count());
  endtask

  // pick a sample whose decoded bit is d, random magnitude
  task automatic send_decoded(logic d);
    logic                       now_bit;
    int                         m;
    logic signed [SAMPLE_W-1:0] s;
    now_bit = sb.rx_prev ^ d;
    if (now_bit) begin
      s = SAMPLE_W'($urandom_range(127, 1));
    end else begin
      m = $urandom_range(128, 0);
      s = SAMPLE_W'(256 - m);
    end
    send_word(s, rand_count());
  endtask

  // feed the marker run until the block locks or the tries run out
  task automatic lock_attempts(int tries);
    int t;
    t = 0;
    while (t < tries && !sb.framing) begin
      for (int j = 0; j < LOCK_RUN && !sb.framing; j++) send_decoded(pn_run[j]);
      t++;
    end
  endtask

  // random frame content until the frame ends
  task automatic ride_frame();
    int guard;
    guard = 0;
    while (sb.framing && guard < 4096) begin
      send_noise(1);
      guard++;
    end
  endtask

  task automatic put_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= v;
    @(posedge clk);
    sb.write_register(idx, v);
  endtask

  task automatic set_config(logic en, int thr, int ceil_val, int fbits);
    put_reg(REG_RESYNC_ENABLE, CFG_DATA_W'(en));
    put_reg(REG_LOCK_THRESHOLD, CFG_DATA_W'(thr));
    put_reg(REG_SCORE_CEILING, CFG_DATA_W'(ceil_val));
    put_reg(REG_FRAME_BITS, CFG_DATA_W'(fbits));
    wr_en <= 1'b0;
  endtask

  // wait until every owed word has come, then stay quiet before the next step
  task automatic settle();
    sample_valid <= 1'b0;
    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    sb           = new();
    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    sample_count = '0;
    symbol_stall = 1'b0;
    wr_en        = 1'b0;
    wr_index     = REG_RESYNC_ENABLE;
    wr_data      = '0;
    // marker bits last, earlier bits by running the recurrence backward
    for (int k = 0; k < 64; k++) pn_run[LOCK_RUN - 64 + k] = SYNC_MARKER[63 - k];
    for (int i = LOCK_RUN - 65; i >= 0; i--) pn_run[i] = pn_run[i + 15] ^ pn_run[i + 1];
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes while hunting, zero and full-scale magnitudes
    send_word(8'h7F, '0);
    send_word(8'h80, '1);
    send_word(8'h00, rand_count());
    send_word(8'h01, '0);
    send_word(8'hFF, '1);
    send_word(8'h81, rand_count());
    send_word(8'h00, rand_count());
    send_word(8'h40, rand_count());
    send_word(8'hC0, rand_count());
    send_word(8'h02, rand_count());
    send_word(8'h7F, rand_count());
    send_word(8'h80, rand_count());
    settle();
    // directed: resync off passes samples unchanged
    set_config(1'b0, 1000, 5000, 354848);
    send_word(8'h80, rand_count());
    send_word(8'h7F, rand_count());
    send_word(8'h00, rand_count());
    send_word(8'hFF, rand_count());
    send_word(8'h55, rand_count());
    settle();

    // lock out of reach: the marker run only builds up the score
    set_config(1'b1, 8191, 8191, 1048575);
    lock_attempts(1);
    send_noise(6);
    settle();
    // pass through with a high score held in the state
    set_config(1'b0, 0, 1, 354848);
    send_noise(8);
    settle();

    // ceiling below the held score, then lock and a frame over the timestamp bytes
    snd_idle = 50;
    rcv_idle = 33;
    set_config(1'b1, 2, 40, 226);
    lock_attempts(4);
    ride_frame();
    send_noise(6);
    settle();

    // lowest threshold, ceiling of one, one-bit frame
    snd_idle = 0;
    rcv_idle = 0;
    set_config(1'b1, 0, 1, 1);
    lock_attempts(4);
    ride_frame();
    send_noise(20);
    settle();

    if (sb.errors == 0) begin
      $display("[pn_lock_frame_resync] OK");
    end else begin
      $display("[pn_lock_frame_resync] ERROR");
    end
    $finish;
  end

endmodule
